@@ hw/rtl/sha256_pkg.sv @@
// Shared types, constants and functions for the SHA-256 hasher.
`default_nettype none
package sha256_pkg;

	typedef enum logic [1:0] {
		OP_WORD = 2'b01,  // word belongs to the block, compress when full
		OP_LAST = 2'b10   // word closes the block, then pad, length and digest
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] word;
		logic [5:0]  bits;   // bits that this beat adds to the length
	} cmd_t;

	localparam int unsigned QueueDepth = 2;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
		rotr = (v >> s) | (v << (32 - s));
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/sha256_front.sv @@
// Input stage: classify beats, apply padding to the last word, queue commands.
`default_nettype none
module sha256_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [39:0]        s_tdata,
	input  wire logic               s_tlast,
	output logic                    cmd_valid,
	input  wire logic               cmd_take,
	output sha256_pkg::cmd_t        cmd
);
	localparam int unsigned Depth = sha256_pkg::QueueDepth;

	sha256_pkg::cmd_t q_mem_q [Depth];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;
	logic [2:0]       cnt;
	logic [31:0]      keep, pad_word, word;
	sha256_pkg::cmd_t new_cmd;
	logic             push, pop;

	assign word = s_tdata[31:0];
	always_comb begin
		cnt = s_tdata[34:32];
		if (!s_tlast || cnt > 3'd4)
			cnt = 3'd4;
		case (cnt)
			3'd0: keep = 32'h0000_0000;
			3'd1: keep = 32'hff00_0000;
			3'd2: keep = 32'hffff_0000;
			3'd3: keep = 32'hffff_ff00;
			default: keep = 32'hffff_ffff;
		endcase
		case (cnt)
			3'd0: pad_word = 32'h8000_0000;
			3'd1: pad_word = (word & keep) | 32'h0080_0000;
			3'd2: pad_word = (word & keep) | 32'h0000_8000;
			3'd3: pad_word = (word & keep) | 32'h0000_0080;
			default: pad_word = word;
		endcase
		new_cmd.word = pad_word;
		new_cmd.bits = {cnt, 3'b000};
		// A full last word still goes in as data; the back end adds the pad word.
		new_cmd.op = s_tlast ? sha256_pkg::OP_LAST : sha256_pkg::OP_WORD;
	end

	assign s_tready  = (count_q != 2'(Depth));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_take;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'(Depth))
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue count lost a push");
endmodule
`default_nettype wire

@@ hw/rtl/sha256_back.sv @@
// Compression engine: block buffer, 64-round loop, padding blocks, digest output.
`default_nettype none
module sha256_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_take,
	input  wire sha256_pkg::cmd_t   cmd,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [31:0]             m_tdata,
	output logic [3:0]              m_tuser,
	output logic                    m_tlast
);
	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_ROUND = 7'b0000010,
		ST_ADD   = 7'b0000100,
		ST_PAD   = 7'b0001000,  // put the trailing 0x80 word
		ST_ZERO  = 7'b0010000,  // zero fill and length words
		ST_OUT   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] w_q [16];       // rolling schedule window, also the block buffer
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]  round_q;
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic        final_q;        // padding pending after this block
	logic        need_pad_q;     // full last word: pad word still to come
	logic        len_blk_q;      // current block carries the length
	logic [2:0]  out_idx_q;

	logic [31:0] t1, t2, s0, s1, w_new, wt;

	always_comb begin
		wt = w_q[0];
		s0 = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19)
		     ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		t1 = hh_q + (sha256_pkg::rotr(e_q, 6) ^ sha256_pkg::rotr(e_q, 11)
		     ^ sha256_pkg::rotr(e_q, 25)) + ((e_q & f_q) ^ (~e_q & g_q))
		     + sha256_pkg::RoundConst[round_q] + wt;
		t2 = (sha256_pkg::rotr(a_q, 2) ^ sha256_pkg::rotr(a_q, 13)
		     ^ sha256_pkg::rotr(a_q, 22)) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = h_q[out_idx_q];
	assign m_tuser  = {(out_idx_q == 3'd7), out_idx_q};
	assign m_tlast  = (out_idx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			w_q[fill_q] <= cmd.word;
		end else if (state_q == ST_PAD) begin
			w_q[fill_q] <= 32'h8000_0000;
		end else if (state_q == ST_ZERO) begin
			if (len_blk_q && fill_q == 4'd14)
				w_q[14] <= bits_q[63:32];
			else if (len_blk_q && fill_q == 4'd15)
				w_q[15] <= bits_q[31:0];
			else
				w_q[fill_q] <= 32'h0;
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
		if (state_q == ST_ROUND) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end else begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			round_q    <= 6'd0;
			fill_q     <= 4'd0;
			bits_q     <= 64'd0;
			final_q    <= 1'b0;
			need_pad_q <= 1'b0;
			len_blk_q  <= 1'b0;
			out_idx_q  <= 3'd0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= sha256_pkg::InitHash[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						bits_q  <= bits_q + 64'(cmd.bits);
						fill_q  <= fill_q + 4'd1;
						round_q <= 6'd0;
						if (cmd.op == sha256_pkg::OP_LAST) begin
							final_q    <= 1'b1;
							need_pad_q <= (cmd.bits == 6'd32);
							len_blk_q  <= 1'b0;
							if (cmd.bits == 6'd32)
								state_q <= (fill_q == 4'd15) ? ST_ROUND : ST_PAD;
							else
								state_q <= (fill_q == 4'd15) ? ST_ROUND : ST_ZERO;
						end else if (fill_q == 4'd15) begin
							state_q <= ST_ROUND;
						end
					end
				end
				ST_PAD: begin
					need_pad_q <= 1'b0;
					fill_q     <= fill_q + 4'd1;
					state_q    <= (fill_q == 4'd15) ? ST_ROUND : ST_ZERO;
				end
				ST_ZERO: begin
					if (!len_blk_q && fill_q == 4'd14) begin
						len_blk_q <= 1'b1;
					end else begin
						fill_q <= fill_q + 4'd1;
						if (fill_q == 4'd15)
							state_q <= ST_ROUND;
					end
					// Hold here until the length words land; the block fits if 14 reached.
					if (!len_blk_q && fill_q < 4'd14)
						len_blk_q <= (fill_q == 4'd13);
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
					h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
					fill_q <= 4'd0;
					if (!final_q)
						state_q <= ST_IDLE;
					else if (len_blk_q)
						state_q <= ST_OUT;
					else if (need_pad_q)
						state_q <= ST_PAD;
					else
						state_q <= ST_ZERO;
				end
				ST_OUT: begin
					if (m_tready) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7)
							state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= sha256_pkg::InitHash[i];
					bits_q    <= 64'd0;
					final_q   <= 1'b0;
					len_blk_q <= 1'b0;
					fill_q    <= 4'd0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid |-> final_q && len_blk_q)
		else $error("digest shown before the length block");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND && round_q == 6'd63 |=> state_q == ST_ADD)
		else $error("round loop did not end in add");
	assert property (@(posedge clk) disable iff (!arst_n) cmd_take |-> state_q == ST_IDLE)
		else $error("command taken while busy");
endmodule
`default_nettype wire

@@ hw/rtl/sha256_message_hasher_core.sv @@
// Top level of the streaming SHA-256 hasher.
// A word that fills a block sets off the 64 compression rounds and the add;
// other words are only stored in the back end. A last beat runs one or two padded
// blocks and then sends eight digest beats. The single round unit sets the rate:
// no new word is taken while a block is being compressed.
// Reset (arst_n low) loads the initial hash and empties queue.
`default_nettype none
module sha256_message_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
	input  wire logic        s_tlast,   // last_item
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] digest_word
	output logic [3:0]       m_tuser,   // [2:0] word_index, [3] last_word
	output logic             m_tlast    // last_word
);
	logic             cmd_valid, cmd_take;
	sha256_pkg::cmd_t cmd;

	// Front: accept beats, fold padding into short last words, buffer two commands.
	sha256_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
		.cmd_valid, .cmd_take, .cmd
	);

	// Back: gather blocks, compress, finish the message and stream the digest.
	sha256_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);
endmodule
`default_nettype wire
